/* hw/rtl/cpu_6502_subset_executor_assert.svh */
// Assertion macros for the 6502 subset executor
`ifndef CPU_6502_SUBSET_EXECUTOR_ASSERT_SVH
`define CPU_6502_SUBSET_EXECUTOR_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* hw/rtl/c6502_pkg.sv */
package c6502_pkg;
   localparam int ADDR_BITS_DEF = 16;
   localparam logic [15:0] RESET_VECTOR = 16'hFFFC;
   localparam logic [7:0] STATUS_RESET = 8'h20;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_EXEC = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_VEC_LO, ST_VEC_HI, ST_FETCH, ST_DECODE, ST_OPND1, ST_OPND2,
      ST_PTR_LO, ST_PTR_HI, ST_DATA, ST_WBACK, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      AM_IMM, AM_ZP, AM_ZPX, AM_ABS, AM_ABSX, AM_ABSY, AM_INDX, AM_INDY, AM_ACC
   } amode_type;

   typedef enum logic [2:0] {
      K_BAD, K_ADC, K_AND, K_LDA, K_ASL, K_BIT, K_IMPL, K_BRANCH
   } kind_type;

   typedef struct packed {
      kind_type  kind;
      amode_type mode;
   } decode_type;

   function automatic amode_type group_mode(input logic [7:0] op);
      case (op[4:2])
         3'd0: return AM_INDX;
         3'd1: return AM_ZP;
         3'd2: return AM_IMM;
         3'd3: return AM_ABS;
         3'd4: return AM_INDY;
         3'd5: return AM_ZPX;
         3'd6: return AM_ABSY;
         default: return AM_ABSX;
      endcase
   endfunction

   function automatic decode_type decode(input logic [7:0] op);
      decode_type d;
      d.kind = K_BAD;
      d.mode = AM_ACC;
      case (op)
         8'h00, 8'h18, 8'hD8, 8'h58, 8'hB8, 8'hAA, 8'hE8, 8'hC8: d.kind = K_IMPL;
         8'h24: begin d.kind = K_BIT; d.mode = AM_ZP; end
         8'h2C: begin d.kind = K_BIT; d.mode = AM_ABS; end
         8'h0A: begin d.kind = K_ASL; d.mode = AM_ACC; end
         8'h06: begin d.kind = K_ASL; d.mode = AM_ZP; end
         8'h16: begin d.kind = K_ASL; d.mode = AM_ZPX; end
         8'h0E: begin d.kind = K_ASL; d.mode = AM_ABS; end
         8'h1E: begin d.kind = K_ASL; d.mode = AM_ABSX; end
         8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: begin
            d.kind = K_ADC; d.mode = group_mode(op);
         end
         8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: begin
            d.kind = K_AND; d.mode = group_mode(op);
         end
         8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: begin
            d.kind = K_LDA; d.mode = group_mode(op);
         end
         default: if (op[4:0] == 5'h10) d.kind = K_BRANCH;
      endcase
      return d;
   endfunction
endpackage

/* hw/rtl/cpu_6502_subset_executor.sv */
// channel | ports                                   | direction
// request | start, busy, req_operation/address/data | in, busy out
// result  | rsp_valid, rsp_* fields                 | out, one cycle strobe
// A request is taken only in the idle state. A write, or an execute while
// halted, goes straight to the result; reset reads the vector bytes; an
// execute reads opcode, operand, pointer and data bytes as its mode needs,
// one read at a time on the read port of the byte memory. ASL writes memory
// back in its data cycle. Memory contents are not cleared by reset.
// Synchronous reset clears PC, A, X, Y and halt flags, sets status to 20h.
// The result strobe cannot be stalled; busy stays high until it is shown.
`include "cpu_6502_subset_executor_assert.svh"
module cpu_6502_subset_executor #(
   parameter int ADDR_BITS = c6502_pkg::ADDR_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_operation,
   input  logic [ADDR_BITS-1:0] req_address,
   input  logic [7:0]           req_data,
   output logic                 rsp_valid,
   output logic [ADDR_BITS-1:0] rsp_program_counter,
   output logic [7:0]           rsp_accumulator,
   output logic [7:0]           rsp_index_x,
   output logic [7:0]           rsp_index_y,
   output logic [7:0]           rsp_flags,
   output logic                 rsp_halted,
   output logic                 rsp_bad_opcode
);
   import c6502_pkg::*;

   logic [7:0] mem [2**ADDR_BITS];
   logic [7:0] rdata;
   logic [ADDR_BITS-1:0] raddr;
   logic                 we;
   logic [ADDR_BITS-1:0] waddr;
   logic [7:0]           wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end

   state_type state_ff, state_in;
   logic [ADDR_BITS-1:0] pc_ff, pc_in, ea_ff, ea_in;
   logic [7:0] a_ff, a_in, x_ff, x_in, y_ff, y_in, p_ff, p_in, op_ff, op_in;
   logic [7:0] lo_ff, lo_in;
   logic stop_ff, stop_in, bad_ff, bad_in;
   decode_type dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0; a_ff <= '0; x_ff <= '0; y_ff <= '0;
         p_ff <= STATUS_RESET; stop_ff <= 1'b0; bad_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in; a_ff <= a_in; x_ff <= x_in; y_ff <= y_in;
         p_ff <= p_in; stop_ff <= stop_in; bad_ff <= bad_in;
      end
      ea_ff <= ea_in; op_ff <= op_in; lo_ff <= lo_in;
   end

   assign dec = decode(op_ff);

   logic [8:0] sum;
   logic [7:0] asl_r, m_val, res;
   logic [ADDR_BITS-1:0] pc1, pc2;
   logic take;
   always_comb begin
      m_val = (dec.mode == AM_ACC) ? a_ff : rdata;
      sum = {1'b0, a_ff} + {1'b0, m_val} + {8'd0, p_ff[0]};
      asl_r = {m_val[6:0], 1'b0};
      pc1 = pc_ff + ADDR_BITS'(1);
      pc2 = pc_ff + ADDR_BITS'(2);
      case (op_ff[7:6])
         2'd0: take = p_ff[7] == op_ff[5];
         2'd1: take = p_ff[6] == op_ff[5];
         2'd2: take = p_ff[0] == op_ff[5];
         default: take = p_ff[1] == op_ff[5];
      endcase
      res = 8'd0;
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff; a_in = a_ff; x_in = x_ff; y_in = y_ff; p_in = p_ff;
      stop_in = stop_ff; bad_in = bad_ff; ea_in = ea_ff; op_in = op_ff;
      lo_in = lo_ff;
      raddr = pc_ff; we = 1'b0; waddr = req_address; wdata = req_data;
      case (state_ff)
         ST_IDLE: if (start) begin
            bad_in = 1'b0;
            case (req_operation)
               OP_WRITE: begin we = 1'b1; state_in = ST_DONE; end
               OP_RESET: begin raddr = RESET_VECTOR; state_in = ST_VEC_LO; end
               OP_EXEC: if (stop_ff) state_in = ST_DONE;
                        else begin raddr = pc_ff; state_in = ST_DECODE; end
               default: state_in = ST_DONE;
            endcase
         end
         ST_VEC_LO: begin
            lo_in = rdata; raddr = RESET_VECTOR + ADDR_BITS'(1);
            state_in = ST_VEC_HI;
         end
         ST_VEC_HI: begin
            pc_in = {rdata, lo_ff}; a_in = '0; x_in = '0; y_in = '0;
            p_in = STATUS_RESET; stop_in = 1'b0; state_in = ST_DONE;
         end
         ST_DECODE: begin
            op_in = rdata; raddr = pc1; state_in = ST_OPND1;
         end
         ST_OPND1: begin
            // rdata holds byte after opcode
            state_in = ST_DONE;
            case (dec.kind)
               K_BAD: begin stop_in = 1'b1; bad_in = 1'b1; end
               K_BRANCH: pc_in = take ? pc2 + {{(ADDR_BITS-8){rdata[7]}}, rdata} : pc2;
               K_IMPL: begin
                  pc_in = pc1;
                  case (op_ff)
                     8'h00: stop_in = 1'b1;
                     8'h18: p_in[0] = 1'b0;
                     8'hD8: p_in[3] = 1'b0;
                     8'h58: p_in[2] = 1'b0;
                     8'hB8: p_in[6] = 1'b0;
                     8'hAA: begin x_in = a_ff; p_in[7] = a_ff[7]; p_in[1] = a_ff == 0; end
                     8'hE8: begin x_in = x_ff + 8'd1; p_in[7] = x_in[7];
                                  p_in[1] = x_in == 0; end
                     default: begin y_in = y_ff + 8'd1; p_in[7] = y_in[7];
                                  p_in[1] = y_in == 0; end
                  endcase
               end
               default: begin
                  lo_in = rdata;
                  case (dec.mode)
                     AM_ACC: state_in = ST_DATA;
                     AM_IMM: begin raddr = pc1; ea_in = pc1; state_in = ST_DATA; end
                     AM_ZP: begin ea_in = {{(ADDR_BITS-8){1'b0}}, rdata};
                                  raddr = ea_in; state_in = ST_DATA; end
                     AM_ZPX: begin ea_in = {{(ADDR_BITS-8){1'b0}}, rdata + x_ff};
                                  raddr = ea_in; state_in = ST_DATA; end
                     AM_INDX: begin ea_in = {{(ADDR_BITS-8){1'b0}}, rdata + x_ff};
                                  raddr = ea_in; state_in = ST_PTR_LO; end
                     AM_INDY: begin ea_in = {{(ADDR_BITS-8){1'b0}}, rdata};
                                  raddr = ea_in; state_in = ST_PTR_LO; end
                     default: begin raddr = pc2; state_in = ST_OPND2; end
                  endcase
               end
            endcase
         end
         ST_OPND2: begin
            case (dec.mode)
               AM_ABSX: ea_in = {rdata, lo_ff} + {{(ADDR_BITS-8){1'b0}}, x_ff};
               AM_ABSY: ea_in = {rdata, lo_ff} + {{(ADDR_BITS-8){1'b0}}, y_ff};
               default: ea_in = {rdata, lo_ff};
            endcase
            raddr = ea_in; state_in = ST_DATA;
         end
         ST_PTR_LO: begin
            lo_in = rdata;
            raddr = {{(ADDR_BITS-8){1'b0}}, ea_ff[7:0] + 8'd1};
            state_in = ST_PTR_HI;
         end
         ST_PTR_HI: begin
            ea_in = {rdata, lo_ff} + ((dec.mode == AM_INDY) ?
                     {{(ADDR_BITS-8){1'b0}}, y_ff} : '0);
            raddr = ea_in; state_in = ST_DATA;
         end
         ST_DATA: begin
            state_in = ST_DONE;
            case (dec.mode)
               AM_ACC: pc_in = pc1;
               AM_ABS, AM_ABSX, AM_ABSY: pc_in = pc2 + ADDR_BITS'(1);
               default: pc_in = pc2;
            endcase
            case (dec.kind)
               K_ADC: begin
                  a_in = sum[7:0]; p_in[0] = sum[8];
                  p_in[6] = ~(a_ff[7] ^ m_val[7]) & (a_ff[7] ^ sum[7]);
                  p_in[7] = sum[7]; p_in[1] = sum[7:0] == 0;
               end
               K_AND: begin a_in = a_ff & m_val; p_in[7] = a_in[7]; p_in[1] = a_in == 0; end
               K_LDA: begin a_in = m_val; p_in[7] = m_val[7]; p_in[1] = m_val == 0; end
               K_BIT: begin
                  p_in[1] = (a_ff & m_val) == 0; p_in[7] = m_val[7]; p_in[6] = m_val[6];
               end
               default: begin
                  p_in[0] = m_val[7]; p_in[7] = asl_r[7]; p_in[1] = asl_r == 0;
                  if (dec.mode == AM_ACC) a_in = asl_r;
                  else begin we = 1'b1; waddr = ea_ff; wdata = asl_r | res; end
               end
            endcase
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy = state_ff != ST_IDLE;
      rsp_valid = state_ff == ST_DONE;
      rsp_program_counter = pc_ff;
      rsp_accumulator = a_ff;
      rsp_index_x = x_ff;
      rsp_index_y = y_ff;
      rsp_flags = p_ff;
      rsp_halted = stop_ff;
      rsp_bad_opcode = bad_ff;
   end

   `ASSERT_IMPLIES(a_bad_halts, clock, reset, rsp_valid && rsp_bad_opcode, rsp_halted)
   `ASSERT_NEXT(a_done_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPLIES(a_flag_bit5, clock, reset, rsp_valid, rsp_flags[5])
endmodule
